/* rtl/oaht_pkg.sv */
// Shared constants for the open-addressed hash table: request and status
// codes, default sizes and probe constants. No dependencies.
package oaht_pkg;

  localparam int TABLE_BITS_DEF = 10;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;

  localparam int HASH_W   = 64;
  localparam int ACT_W    = 4;
  localparam int PERT_SH  = 5;
  localparam int PERT_W   = HASH_W - PERT_SH;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 3;
  localparam int EXTRA_PROBES = 16;

  localparam logic [ACT_W-1:0] ACT_RESET = 4'd10;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_NEXT   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_NEW      = 3'd0;
  localparam logic [STAT_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] ST_END      = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd6;

endpackage

/* rtl/open_address_hash_table.sv */
// Open-addressed key/value table with perturbation probing, top level.
// Depends on oaht_pkg and oaht_step.
//
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | req_type, key, hash_value, value, start_slot
// out_    | output    | out_valid/out_stall| status, slot_index, found_key, found_value, entry_total
// cfg_    | input     | cfg_valid/cfg_ready| data (active_bits, 4 bits)
//
// Steps: an item is accepted, then each slot probed takes a read (S_PROBE) and
//   a check (S_CHK), then the result is staged (S_RES); next-occupied scans
//   slots the same way; a full refusal or an end at accept goes straight to S_RES.
//   The slot memory (one registered read per probe) sets this.
// Clear: a clear request sweeps the valid bits one slot a cycle, over every
//   slot of the table. Reset runs the same sweep before in_stall drops.
// Stalls: in_stall is high while an item is in work; a finished result waits in
//   a staging register until the output register frees up.
module open_address_hash_table import oaht_pkg::*; #(
  parameter int TABLE_BITS = TABLE_BITS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [HASH_W-1:0]     in_hash_value,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [TABLE_BITS:0]   in_start_slot,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     out_status,
  output logic [TABLE_BITS-1:0] out_slot_index,
  output logic [KEY_BITS-1:0]   out_found_key,
  output logic [VALUE_BITS-1:0] out_found_value,
  output logic [TABLE_BITS:0]   out_entry_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ACT_W-1:0]      cfg_data
);

  localparam int SLOTS = 1 << TABLE_BITS;
  localparam int ENT_W = 1 + HASH_W + KEY_BITS + VALUE_BITS;
  localparam int CNT_W = TABLE_BITS + 5;

  typedef enum logic [4:0] {
    S_CLR   = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PROBE = 5'b00100,
    S_CHK   = 5'b01000,
    S_RES   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // slot memory: {valid, hash, key, value}
  logic [ENT_W-1:0] mem [SLOTS];
  logic [ENT_W-1:0] rd_q;
  logic             wr_en;
  logic [TABLE_BITS-1:0] wr_addr, rd_addr;
  logic [ENT_W-1:0] wr_data;

  logic [ACT_W-1:0]      active_r;
  logic [TABLE_BITS:0]   count_r, count_nxt;
  logic [TABLE_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic                  clr_req_r, clr_req_nxt;

  logic [REQ_W-1:0]      req_r, req_nxt;
  logic [HASH_W-1:0]     hash_r, hash_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [PERT_W-1:0]     pert_r, pert_nxt;
  logic [TABLE_BITS:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;

  logic [STAT_W-1:0]     res_status_r, res_status_nxt;
  logic [TABLE_BITS-1:0] res_slot_r, res_slot_nxt;
  logic [KEY_BITS-1:0]   res_key_r, res_key_nxt;
  logic [VALUE_BITS-1:0] res_val_r, res_val_nxt;

  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [TABLE_BITS-1:0] out_slot_r;
  logic [KEY_BITS-1:0]   out_key_r;
  logic [VALUE_BITS-1:0] out_val_r;
  logic [TABLE_BITS:0]   out_total_r;

  logic [4:0]            eff;
  logic [TABLE_BITS:0]   cap;
  logic [TABLE_BITS-1:0] mask;
  logic [TABLE_BITS+2:0] load3;
  logic [CNT_W-1:0]      limit;
  logic [HASH_W-1:0]     hash_in;
  logic                  accept, out_free;

  logic                  e_valid;
  logic [HASH_W-1:0]     e_hash;
  logic [KEY_BITS-1:0]   e_key;
  logic [VALUE_BITS-1:0] e_val;

  logic [TABLE_BITS-1:0] step_idx;
  logic [PERT_W-1:0]     step_pert;

  oaht_step #(.TABLE_BITS(TABLE_BITS)) u_step (
    .idx      (idx_r[TABLE_BITS-1:0]),
    .pert     (pert_r),
    .mask     (mask),
    .idx_nxt  (step_idx),
    .pert_nxt (step_pert)
  );

  // Clamp active width: zero acts as one, above TABLE_BITS acts as TABLE_BITS.
  always_comb begin
    if (active_r == '0) begin
      eff = 5'd1;
    end else if ({1'b0, active_r} > 5'(TABLE_BITS)) begin
      eff = 5'(TABLE_BITS);
    end else begin
      eff = {1'b0, active_r};
    end
    cap   = {{TABLE_BITS{1'b0}}, 1'b1} << eff;
    mask  = TABLE_BITS'(cap - 1'b1);
    load3 = ({2'b00, count_r} + {1'b0, count_r, 1'b0}) >> 1;
    limit = (req_r == REQ_INSERT) ? CNT_W'(cap) + CNT_W'(EXTRA_PROBES) : CNT_W'(cap);
    hash_in = (in_hash_value == '1) ? '0 : in_hash_value;
  end

  assign {e_valid, e_hash, e_key, e_val} = rd_q;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    clr_idx_nxt    = clr_idx_r;
    clr_req_nxt    = clr_req_r;
    req_nxt        = req_r;
    hash_nxt       = hash_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    pert_nxt       = pert_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_key_nxt    = res_key_r;
    res_val_nxt    = res_val_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r[TABLE_BITS-1:0];
    wr_data        = {1'b1, hash_r, key_r, val_r};
    rd_addr        = idx_r[TABLE_BITS-1:0];

    case (state_r)
      S_CLR: begin
        // sweep one slot a cycle, invalidating it
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        wr_data = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == TABLE_BITS'(SLOTS - 1)) begin
          if (clr_req_r) begin
            res_status_nxt = ST_CLEARED;
            state_nxt      = S_RES;
          end else begin
            state_nxt = S_IDLE;
          end
          clr_req_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt  = in_req_type;
          hash_nxt = hash_in;
          key_nxt  = in_key;
          val_nxt  = in_value;
          pert_nxt = hash_in[HASH_W-1:PERT_SH];
          n_nxt    = '0;
          res_slot_nxt = '0;
          res_key_nxt  = '0;
          res_val_nxt  = '0;
          case (in_req_type)
            REQ_INSERT, REQ_LOOKUP: begin
              idx_nxt = {1'b0, hash_in[TABLE_BITS-1:0] & mask};
              if (in_req_type == REQ_INSERT && load3 >= {2'b00, cap}) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_RES;
              end else begin
                state_nxt = S_PROBE;
              end
            end
            REQ_NEXT: begin
              idx_nxt = in_start_slot;
              if (in_start_slot >= cap) begin
                res_status_nxt = ST_END;
                state_nxt      = S_RES;
              end else begin
                state_nxt = S_PROBE;
              end
            end
            default: begin
              count_nxt   = '0;
              clr_idx_nxt = '0;
              clr_req_nxt = 1'b1;
              state_nxt   = S_CLR;
            end
          endcase
        end
      end
      S_PROBE: begin
        // issue the slot read; data returns next cycle
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_PROBE;
        if (req_r == REQ_NEXT) begin
          if (e_valid) begin
            res_status_nxt = ST_FOUND;
            res_slot_nxt   = idx_r[TABLE_BITS-1:0];
            res_key_nxt    = e_key;
            res_val_nxt    = e_val;
            state_nxt      = S_RES;
          end else if (idx_r + 1'b1 >= cap) begin
            res_status_nxt = ST_END;
            state_nxt      = S_RES;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (!e_valid) begin
          if (req_r == REQ_INSERT) begin
            wr_en          = 1'b1;
            count_nxt      = count_r + 1'b1;
            res_status_nxt = ST_NEW;
            res_slot_nxt   = idx_r[TABLE_BITS-1:0];
            res_key_nxt    = key_r;
            res_val_nxt    = val_r;
          end else begin
            res_status_nxt = ST_NOTFOUND;
          end
          state_nxt = S_RES;
        end else if (e_hash == hash_r && e_key == key_r) begin
          res_slot_nxt = idx_r[TABLE_BITS-1:0];
          res_key_nxt  = e_key;
          if (req_r == REQ_INSERT) begin
            wr_en          = 1'b1;
            res_status_nxt = ST_REPLACED;
            res_val_nxt    = val_r;
          end else begin
            res_status_nxt = ST_FOUND;
            res_val_nxt    = e_val;
          end
          state_nxt = S_RES;
        end else if (n_r + 1'b1 >= limit) begin
          // give up: path exhausted
          res_status_nxt = (req_r == REQ_INSERT) ? ST_FULL : ST_NOTFOUND;
          state_nxt      = S_RES;
        end else begin
          n_nxt    = n_r + 1'b1;
          idx_nxt  = {1'b0, step_idx};
          pert_nxt = step_pert;
        end
      end
      S_RES: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      active_r    <= ACT_RESET;
      count_r     <= '0;
      clr_idx_r   <= '0;
      clr_req_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      clr_idx_r <= clr_idx_nxt;
      clr_req_r <= clr_req_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      if (state_r == S_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    hash_r       <= hash_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    pert_r       <= pert_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_key_r    <= res_key_nxt;
    res_val_r    <= res_val_nxt;
    if (state_r == S_RES && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_key_r    <= res_key_r;
      out_val_r    <= res_val_r;
      out_total_r  <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_r;
  assign out_found_key   = out_key_r;
  assign out_found_value = out_val_r;
  assign out_entry_total = out_total_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (TABLE_BITS+1)'(SLOTS)) else $error("entry count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && count_nxt != count_r) |-> (wr_en && !e_valid))
    else $error("entry count moved without a new insert");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |=> (count_r == '0)) else $error("count not zero during clear");

endmodule

/* rtl/oaht_step.sv */
// Probe step unit: shifts the perturbation and forms the next slot index.
// Depends on oaht_pkg.
module oaht_step import oaht_pkg::*; #(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic [TABLE_BITS-1:0] idx,
  input  logic [PERT_W-1:0]     pert,
  input  logic [TABLE_BITS-1:0] mask,
  output logic [TABLE_BITS-1:0] idx_nxt,
  output logic [PERT_W-1:0]     pert_nxt
);

  logic [TABLE_BITS-1:0] sum;

  always_comb begin
    pert_nxt = pert >> PERT_SH;
    // 5*i + perturb + 1, modulo the active table size (mask)
    sum = (idx << 2) + idx + pert_nxt[TABLE_BITS-1:0] + {{(TABLE_BITS-1){1'b0}}, 1'b1};
    idx_nxt = sum & mask;
  end

endmodule
